>>> hdl/int64_divider_signed_unsigned_macros.svh
// assertion macros for the int64 divider
// no dependencies; included by the top level
`ifndef INT64_DIVIDER_SIGNED_UNSIGNED_MACROS_SVH
`define INT64_DIVIDER_SIGNED_UNSIGNED_MACROS_SVH

// concurrent assertion on a given clock and active-low reset
`define I64DIV_ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent assertion on the block clock and reset
`define I64DIV_ASSERT(label, prop, msg) \
  `I64DIV_ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`endif

>>> hdl/i64div_pkg.sv
// shared widths and types of the int64 divider
// no dependencies
package i64div_pkg;

  localparam int unsigned WIDTH = 64;
  localparam int unsigned STEPS = WIDTH;

  typedef logic [WIDTH-1:0] word_t;

  typedef struct packed {
    logic zero;
    logic q_neg;
    logic r_neg;
  } flags_t;

  typedef struct packed {
    logic   valid;
    flags_t flags;
  } meta_t;

endpackage

>>> hdl/i64div_req_if.sv
// request channel of the int64 divider: mode, dividend and divisor
// depends on i64div_pkg
interface i64div_req_if;

  logic              valid;
  logic              ready;
  logic              func;
  i64div_pkg::word_t dividend;
  i64div_pkg::word_t divisor;

  modport source (output valid, func, dividend, divisor, input ready);
  modport sink   (input valid, func, dividend, divisor, output ready);

endinterface

>>> hdl/i64div_rsp_if.sv
// response channel of the int64 divider: quotient and remainder
// depends on i64div_pkg
interface i64div_rsp_if;

  logic              valid;
  logic              ready;
  i64div_pkg::word_t quotient;
  i64div_pkg::word_t remainder;

  modport source (output valid, quotient, remainder, input ready);
  modport sink   (input valid, quotient, remainder, output ready);

endinterface

>>> hdl/i64div_stage.sv
// one registered restoring-division step: one quotient bit per stage
// depends on i64div_pkg
module i64div_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  i64div_pkg::meta_t  meta_i,
  input  i64div_pkg::word_t  rem_i,
  input  i64div_pkg::word_t  num_i,
  input  i64div_pkg::word_t  den_i,
  output i64div_pkg::meta_t  meta_o,
  output i64div_pkg::word_t  rem_o,
  output i64div_pkg::word_t  num_o,
  output i64div_pkg::word_t  den_o
);

  localparam int unsigned W = i64div_pkg::WIDTH;

  logic                 valid_q;
  i64div_pkg::flags_t   flags_q;
  i64div_pkg::word_t    rem_d, rem_q;
  i64div_pkg::word_t    num_d, num_q;
  i64div_pkg::word_t    den_q;
  i64div_pkg::word_t    shifted;
  logic [W:0]           diff;
  logic                 take;

  always_comb begin
    shifted = {rem_i[W-2:0], num_i[W-1]};
    diff    = {rem_i[W-1], shifted} - {1'b0, den_i};
    take    = ~diff[W];
    rem_d   = take ? diff[W-1:0] : shifted;
    num_d   = {num_i[W-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= meta_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flags_q <= meta_i.flags;
      rem_q   <= rem_d;
      num_q   <= num_d;
      den_q   <= den_i;
    end
  end

  assign meta_o = '{valid: valid_q, flags: flags_q};
  assign rem_o  = rem_q;
  assign num_o  = num_q;
  assign den_o  = den_q;

endmodule

>>> hdl/int64_divider_signed_unsigned.sv
// int64 divider, signed and unsigned, fully pipelined
// depends on i64div_pkg, i64div_req_if, i64div_rsp_if, i64div_stage and the macro header
//
// req_i carries func (0 unsigned, 1 signed two's complement), dividend and divisor;
// rsp_o returns quotient and remainder of one division per word.
// signed mode divides magnitudes, negates the quotient when the signs differ and
// gives the remainder the sign of the dividend. a zero divisor gives quotient 0
// and remainder equal to the dividend. most negative over -1 wraps.
// pipeline: one operand stage with the magnitude negate, loaded at the accepting
// edge, then 64 subtract stages and one output stage with the sign fixup.
// throughput: one word per cycle while rsp_o is not stalled; every stage is
// registered and each subtract stage resolves one quotient bit.
// reset clears every stage valid bit; data registers are not reset.
// a stall on rsp_o freezes the whole pipeline; req_i.ready is high whenever
// the output register is empty or its word is taken in the same cycle, so
// nothing is lost or repeated.

`include "int64_divider_signed_unsigned_macros.svh"

module int64_divider_signed_unsigned (
  input  logic            clk_i,
  input  logic            rst_ni,
  i64div_req_if.sink      req_i,
  i64div_rsp_if.source    rsp_o
);

  localparam int unsigned W = i64div_pkg::WIDTH;
  localparam int unsigned S = i64div_pkg::STEPS;

  logic               stage_en;
  logic               a_neg, b_neg;
  i64div_pkg::word_t  ua;

  i64div_pkg::meta_t  m_s [0:S];
  i64div_pkg::word_t  r_s [0:S];
  i64div_pkg::word_t  n_s [0:S];
  i64div_pkg::word_t  d_s [0:S];

  logic               valid0_q;
  i64div_pkg::flags_t flags0_q;
  i64div_pkg::word_t  num0_q, den0_q;

  i64div_pkg::word_t  q_pos, q_fin, r_fin;
  logic               rsp_valid_q;
  i64div_pkg::word_t  quotient_q, remainder_q;

  assign stage_en    = ~rsp_valid_q | rsp_o.ready;
  assign req_i.ready = stage_en;

  // operand stage: magnitudes and sign flags
  always_comb begin
    a_neg = req_i.func & req_i.dividend[W-1];
    b_neg = req_i.func & req_i.divisor[W-1];
    ua    = a_neg ? i64div_pkg::word_t'(~req_i.dividend + i64div_pkg::word_t'(1))
                  : req_i.dividend;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid0_q <= 1'b0;
    end else if (stage_en) begin
      valid0_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en) begin
      flags0_q.zero  <= (req_i.divisor == '0);
      flags0_q.q_neg <= a_neg ^ b_neg;
      flags0_q.r_neg <= a_neg;
      num0_q         <= ua;
      den0_q         <= b_neg ? i64div_pkg::word_t'(~req_i.divisor + i64div_pkg::word_t'(1))
                              : req_i.divisor;
    end
  end

  assign m_s[0] = '{valid: valid0_q, flags: flags0_q};
  assign r_s[0] = '0;
  assign n_s[0] = num0_q;
  assign d_s[0] = den0_q;

  for (genvar k = 0; k < S; k++) begin : g_step
    i64div_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (stage_en),
      .meta_i (m_s[k]),
      .rem_i  (r_s[k]),
      .num_i  (n_s[k]),
      .den_i  (d_s[k]),
      .meta_o (m_s[k+1]),
      .rem_o  (r_s[k+1]),
      .num_o  (n_s[k+1]),
      .den_o  (d_s[k+1])
    );
  end

  // output stage: zero-divisor override and sign fixup
  always_comb begin
    q_pos = m_s[S].flags.zero ? '0 : n_s[S];
    q_fin = m_s[S].flags.q_neg ? i64div_pkg::word_t'(~q_pos + i64div_pkg::word_t'(1))
                               : q_pos;
    r_fin = m_s[S].flags.r_neg ? i64div_pkg::word_t'(~r_s[S] + i64div_pkg::word_t'(1))
                               : r_s[S];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (stage_en) begin
      rsp_valid_q <= m_s[S].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en) begin
      quotient_q  <= q_fin;
      remainder_q <= r_fin;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.quotient  = quotient_q;
  assign rsp_o.remainder = remainder_q;

  `I64DIV_ASSERT(a_rem_below_den, m_s[S].valid && !m_s[S].flags.zero |-> r_s[S] < d_s[S], "remainder not below divisor after last step")
  `I64DIV_ASSERT(a_zero_div_quot, m_s[S].valid && m_s[S].flags.zero && stage_en |=> rsp_o.quotient == '0, "zero divisor gave a nonzero quotient")
  `I64DIV_ASSERT(a_stall_freeze, !stage_en |=> $stable(r_s[S]) && $stable(n_s[S]) && $stable(m_s[S]), "pipeline moved during a stall")

endmodule
